// ===== design/slseq_pkg.sv =====
// shared types, constants and functions of the stepper lock sequencer
package slseq_pkg;

  // number of slaves whose lock replies are ORed together
  localparam int unsigned SLAVE_COUNT = 2;

  // configuration register
  localparam int unsigned DEG_W   = 9;
  localparam int unsigned STEPS_W = 13;

  // degrees to half steps: floor(deg * 512 / 45) as (deg * RECIP) >> RECIP_SHIFT
  localparam int unsigned RECIP_SHIFT = 15;
  localparam int unsigned RECIP       = (512 * (1 << RECIP_SHIFT)) / 45 + 1;
  localparam int unsigned RECIP_W     = 19;
  localparam int unsigned PROD_W      = DEG_W + RECIP_W;
  localparam logic [DEG_W-1:0] RESET_DEGREES = 9'd135;

  // command bytes
  localparam logic [7:0] CMD_LOCK   = 8'h01;
  localparam logic [7:0] CMD_UNLOCK = 8'h02;
  localparam logic [7:0] CMD_RESET  = 8'h80;

  // move direction codes
  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_BACK = 2'd2;

  // motor phase codes
  localparam logic [3:0] MPH_INIT  = 4'd0;
  localparam logic [3:0] MPH_FIRST = 4'd1;
  localparam logic [3:0] MPH_LAST  = 4'd8;

  // controller requests towards the stepper
  typedef struct packed {
    logic               set_dir;
    logic [1:0]         dir;
    logic               load_steps;
    logic [STEPS_W-1:0] steps;
    logic               clear_done;
  } ctl_req_t;

  // half-step coil pattern for a motor phase
  function automatic logic [3:0] coil_lut(input logic [3:0] ph);
    logic [3:0] c;
    case (ph)
      4'd1:    c = 4'h1;
      4'd2:    c = 4'h3;
      4'd3:    c = 4'h2;
      4'd4:    c = 4'h6;
      4'd5:    c = 4'h4;
      4'd6:    c = 4'hC;
      4'd7:    c = 4'h8;
      4'd8:    c = 4'h9;
      default: c = 4'h0;
    endcase
    return c;
  endfunction

  // travel angle to half-step count
  function automatic logic [STEPS_W-1:0] deg_to_steps(input logic [DEG_W-1:0] deg);
    logic [PROD_W-1:0] prod;
    prod = {{RECIP_W{1'b0}}, deg} * PROD_W'(RECIP);
    return prod[RECIP_SHIFT +: STEPS_W];
  endfunction

endpackage

// ===== design/slseq_ifs.sv =====
// handshake channel interfaces for input ticks and results

interface slseq_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] reply_first;
  logic [7:0] reply_second;
  logic       release_button_n;

  modport source (output valid, reply_first, reply_second, release_button_n, input ready);
  modport sink   (input valid, reply_first, reply_second, release_button_n, output ready);
endinterface

interface slseq_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] coil_pattern;
  logic       spi_send;
  logic [7:0] spi_byte;
  logic [7:0] status_leds;
  logic [2:0] lock_phase;

  modport source (output valid, coil_pattern, spi_send, spi_byte, status_leds, lock_phase,
                  input ready);
  modport sink   (input valid, coil_pattern, spi_send, spi_byte, status_leds, lock_phase,
                  output ready);
endinterface

// ===== design/stepper_lock_sequencer_core.sv =====
// stepper lock sequencer: input register, controller, stepper, result register
// a transaction is held in the input register, then its result in the result register
// throughput: one transaction per cycle unless out_chan.ready stalls the result register;
// the state update is one pass of logic between the input register and the result register
// reset: synchronous active-low rst_n clears phases, motor state, status latch
// and sets the travel angle to 135 degrees; the input is ready right after reset
module stepper_lock_sequencer_core
  import slseq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  slseq_in_if.sink         in_chan,
  slseq_out_if.source      out_chan,
  input  logic             cfg_wr_en,
  input  logic [DEG_W-1:0] cfg_wr_data
);

  logic               s1_valid_r;
  logic [7:0]         s1_reply_first_r, s1_reply_second_r;
  logic               s1_button_n_r;
  logic               fire;
  logic [STEPS_W-1:0] travel_steps_r;
  ctl_req_t           req;
  logic               move_done;
  logic               spi_send;
  logic [7:0]         spi_byte;
  logic [7:0]         leds_nxt;
  logic [2:0]         shown_phase;
  logic [3:0]         coil;
  logic               out_valid_r;
  logic [3:0]         coil_r;
  logic               spi_send_r;
  logic [7:0]         spi_byte_r;
  logic [7:0]         leds_r;
  logic [2:0]         phase_out_r;

  // a tick is processed when the result register is free or being drained
  assign fire          = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || fire;

  // travel count worked out when the angle is written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      travel_steps_r <= deg_to_steps(RESET_DEGREES);
    end else if (cfg_wr_en) begin
      travel_steps_r <= deg_to_steps(cfg_wr_data);
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_reply_first_r  <= in_chan.reply_first;
      s1_reply_second_r <= in_chan.reply_second;
      s1_button_n_r     <= in_chan.release_button_n;
    end
  end

  slseq_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .fire             (fire),
    .reply_first      (s1_reply_first_r),
    .reply_second     (s1_reply_second_r),
    .release_button_n (s1_button_n_r),
    .travel_steps     (travel_steps_r),
    .move_done        (move_done),
    .req              (req),
    .spi_send         (spi_send),
    .spi_byte         (spi_byte),
    .leds_nxt         (leds_nxt),
    .shown_phase      (shown_phase)
  );

  slseq_stepper u_stepper (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .req       (req),
    .move_done (move_done),
    .coil      (coil)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      coil_r      <= coil;
      spi_send_r  <= spi_send;
      spi_byte_r  <= spi_byte;
      leds_r      <= leds_nxt;
      phase_out_r <= shown_phase;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.coil_pattern = coil_r;
  assign out_chan.spi_send     = spi_send_r;
  assign out_chan.spi_byte     = spi_byte_r;
  assign out_chan.status_leds  = leds_r;
  assign out_chan.lock_phase   = phase_out_r;

endmodule

// ===== design/slseq_ctrl.sv =====
// lock controller: phase state machine, command bytes and status latch
module slseq_ctrl
  import slseq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  logic [7:0]         reply_first,
  input  logic [7:0]         reply_second,
  input  logic               release_button_n,
  input  logic [STEPS_W-1:0] travel_steps,
  input  logic               move_done,
  output ctl_req_t           req,
  output logic               spi_send,
  output logic [7:0]         spi_byte,
  output logic [7:0]         leds_nxt,
  output logic [2:0]         shown_phase
);

  typedef enum logic [2:0] {
    PH_INIT    = 3'd0,
    PH_LOCK    = 3'd1,
    PH_UNLOCK  = 3'd2,
    PH_OPENING = 3'd3,
    PH_OPEN    = 3'd4,
    PH_RESET   = 3'd5,
    PH_CLOSING = 3'd6
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] leds_r;
  logic [7:0] reply_or;

  // OR of the replies of the fitted slaves
  always_comb begin
    reply_or = 8'h00;
    if (SLAVE_COUNT >= 1) reply_or = reply_or | reply_first;
    if (SLAVE_COUNT >= 2) reply_or = reply_or | reply_second;
  end

  // phase actions for one tick
  always_comb begin
    phase_nxt   = phase_r;
    leds_nxt    = leds_r;
    spi_send    = 1'b0;
    spi_byte    = 8'h00;
    shown_phase = phase_r;
    req         = '0;
    req.dir     = DIR_STOP;
    req.steps   = travel_steps;
    case (phase_r)
      PH_INIT: begin
        req.set_dir    = 1'b1;
        req.load_steps = 1'b1;
        req.steps      = '0;
        req.clear_done = 1'b1;
        phase_nxt      = PH_LOCK;
      end
      PH_LOCK: begin
        req.set_dir = 1'b1;
        spi_send    = 1'b1;
        spi_byte    = CMD_LOCK;
        leds_nxt    = reply_or;
        if (reply_or == 8'h00) phase_nxt = PH_UNLOCK;
      end
      PH_UNLOCK: begin
        req.set_dir    = 1'b1;
        req.dir        = DIR_FWD;
        req.load_steps = 1'b1;
        spi_send       = 1'b1;
        spi_byte       = CMD_UNLOCK;
        phase_nxt      = PH_OPENING;
      end
      PH_OPENING: begin
        if (move_done) begin
          req.clear_done = 1'b1;
          phase_nxt      = PH_OPEN;
        end
      end
      PH_OPEN: begin
        req.set_dir = 1'b1;
        if (!release_button_n) phase_nxt = PH_RESET;
      end
      PH_RESET: begin
        req.set_dir    = 1'b1;
        req.dir        = DIR_BACK;
        req.load_steps = 1'b1;
        spi_send       = 1'b1;
        spi_byte       = CMD_RESET;
        phase_nxt      = PH_CLOSING;
      end
      PH_CLOSING: begin
        if (move_done) begin
          req.clear_done = 1'b1;
          phase_nxt      = PH_LOCK;
        end
      end
      default: begin
        // unused phase code falls back to init
        shown_phase = PH_INIT;
        phase_nxt   = PH_INIT;
      end
    endcase
  end

  // phase and status latch
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_INIT;
      leds_r  <= 8'h00;
    end else if (fire) begin
      phase_r <= phase_nxt;
      leds_r  <= leds_nxt;
    end
  end

endmodule

// ===== design/slseq_stepper.sv =====
// half-step stepper: coil phase walk, step count and move-done flag
module slseq_stepper
  import slseq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     fire,
  input  ctl_req_t req,
  output logic     move_done,
  output logic [3:0] coil
);

  logic [3:0]         motor_r, motor_nxt;
  logic [1:0]         dir_r, dir_m;
  logic [STEPS_W-1:0] steps_r, steps_m, steps_nxt;
  logic               done_r, done_m, done_nxt;

  assign move_done = done_r;

  // controller overrides applied before the step
  always_comb begin
    dir_m   = req.set_dir    ? req.dir   : dir_r;
    steps_m = req.load_steps ? req.steps : steps_r;
    done_m  = req.clear_done ? 1'b0      : done_r;
  end

  // one half step when forward or back is set; the init phase first moves to the first phase
  always_comb begin
    motor_nxt = motor_r;
    steps_nxt = steps_m;
    done_nxt  = done_m;
    coil      = 4'h0;
    if (motor_r == MPH_INIT) begin
      motor_nxt = MPH_FIRST;
    end else if (motor_r <= MPH_LAST) begin
      coil = coil_lut(motor_r);
      if (dir_m == DIR_FWD || dir_m == DIR_BACK) begin
        if (steps_m != '0) steps_nxt = steps_m - STEPS_W'(1);
        if (steps_nxt == '0) done_nxt = 1'b1;
        if (dir_m == DIR_FWD)
          motor_nxt = (motor_r == MPH_LAST) ? MPH_FIRST : motor_r + 4'd1;
        else
          motor_nxt = (motor_r == MPH_FIRST) ? MPH_LAST : motor_r - 4'd1;
      end
    end else begin
      motor_nxt = MPH_INIT;
    end
  end

  // stepper state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motor_r <= MPH_INIT;
      dir_r   <= DIR_STOP;
      steps_r <= '0;
      done_r  <= 1'b0;
    end else if (fire) begin
      motor_r <= motor_nxt;
      dir_r   <= dir_m;
      steps_r <= steps_nxt;
      done_r  <= done_nxt;
    end
  end

endmodule
